// ===== rtl/core/bgi_pkg.sv =====
// bgi_pkg: shared types and constants for the bilinear grid interpolator
// holds opcodes, register indexes, sequencer states and reset values
// no dependencies; used by the core, the grid ram user and the checker
package bgi_pkg;

   // default grid storage size
   localparam int GRID_COLS_DEF = 64;
   localparam int GRID_ROWS_DEF = 64;

   // width for grid dimension compares (grid dimensions up to 1024)
   localparam int DIM_W  = 11;
   // width of a signed cell position after ghost offset
   localparam int POS_W  = 34;
   // shared multiplier operand and product widths
   localparam int MUL_AW = 34;
   localparam int MUL_BW = 18;
   localparam int MUL_PW = MUL_AW + MUL_BW;
   // blend accumulator width
   localparam int ACC_W  = 64;

   // one in Q0.16 weight arithmetic
   localparam logic [16:0] ONE_Q16 = 17'h1_0000;
   // rounding offset added once to the blend accumulator
   localparam logic [ACC_W-1:0] ROUND_HALF = 64'h0000_0000_8000_0000;

   // register reset values
   localparam logic [31:0] X_LOWER_RST     = 32'h0000_0000;
   localparam logic [31:0] Y_LOWER_RST     = 32'h0000_0000;
   localparam logic [30:0] INV_DX_RST      = 31'h0001_0000;
   localparam logic [30:0] INV_DY_RST      = 31'h0001_0000;
   localparam logic [2:0]  GHOST_CELLS_RST = 3'd2;
   localparam logic [6:0]  COLS_IN_USE_RST = 7'd64;
   localparam logic [6:0]  ROWS_IN_USE_RST = 7'd64;

   // item opcodes
   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_INTERP = 1'b1
   } bgi_op_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_X_LOWER     = 3'd0,
      CSR_Y_LOWER     = 3'd1,
      CSR_INV_DX      = 3'd2,
      CSR_INV_DY      = 3'd3,
      CSR_GHOST_CELLS = 3'd4,
      CSR_COLS_IN_USE = 3'd5,
      CSR_ROWS_IN_USE = 3'd6
   } bgi_csr_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_X_LO,
      ST_X_HI,
      ST_Y_LO,
      ST_Y_HI,
      ST_Y_END,
      ST_CHECK,
      ST_WEIGHT,
      ST_PROD_LO,
      ST_PROD_HI,
      ST_SUM,
      ST_OUT
   } bgi_state_type;

endpackage

// ===== rtl/core/bgi_ram.sv =====
// bgi_ram: generic simple dual-port ram, one write and one registered read
// parameters set data width and depth; no package dependency
module bgi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bilinear_grid_interpolator_core.sv =====
// bilinear_grid_interpolator_core: cell grid store and bilinear interpolation
// depends on bgi_pkg and bgi_ram
//
// Usage
// - req_* channel takes items under valid/stall. A write item (operation 0)
//   stores cell_value at write_col, write_row and gives no result.
//   Writes beyond the grid storage are dropped.
// - An interpolate item (operation 1) gives one rsp_* item: interp_value in
//   signed Q16.16 and out_of_grid, with value zero when a neighbour is outside
//   the grid in use.
// - An out-of-grid point skips the blend and goes straight to the output. The
//   block takes no item while it works, so an interpolation is finished before
//   the next item is taken; writes run one per cycle while the block is idle.
// - The sequence is set by one shared 34x18 multiplier: two passes per
//   coordinate, then a weight and two partial products for each of the four
//   neighbours, read one per pass from the single grid memory port.
// - The result sits in an output register; a write item is still taken while
//   rsp_stall holds a finished result, and an interpolation waits at its end
//   until the output register is free.
// - csr_* writes registers by index; always ready, so write only while idle.
// - Reset (synchronous, active high) restores register defaults and empties
//   the output; grid contents are undefined until written.
module bilinear_grid_interpolator_core #(
   parameter int GRID_COLS = bgi_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = bgi_pkg::GRID_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [5:0]  req_write_col,
   input  logic [5:0]  req_write_row,
   input  logic [31:0] req_cell_value,
   input  logic [31:0] req_x_pos,
   input  logic [31:0] req_y_pos,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_interp_value,
   output logic        rsp_out_of_grid,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int COL_W  = $clog2(GRID_COLS);
   localparam int ROW_W  = $clog2(GRID_ROWS);
   localparam int DEPTH  = GRID_COLS * GRID_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int DIM_W  = bgi_pkg::DIM_W;
   localparam int POS_W  = bgi_pkg::POS_W;
   localparam int MUL_AW = bgi_pkg::MUL_AW;
   localparam int MUL_BW = bgi_pkg::MUL_BW;
   localparam int MUL_PW = bgi_pkg::MUL_PW;
   localparam int ACC_W  = bgi_pkg::ACC_W;

   // configuration registers
   logic [31:0] x_lower_ff, y_lower_ff;
   logic [30:0] inv_dx_ff, inv_dy_ff;
   logic [2:0]  ghost_ff;
   logic [6:0]  cols_ff, rows_ff;

   // control state
   bgi_pkg::bgi_state_type state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  corner_ff, corner_in;
   logic        fault_ff, fault_in;

   // payload state
   logic [32:0]            dx_ff, dx_in, dy_ff, dy_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [MUL_PW-1:0] mul_ff, mul_in;
   logic [POS_W-1:0]       cell_x_ff, cell_x_in, cell_y_ff, cell_y_in;
   logic [15:0]            a_ff, a_in, b_ff, b_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [16:0]            whi_ff, whi_in;
   logic [31:0]            rsp_value_ff, rsp_value_in;
   logic                   rsp_oog_ff, rsp_oog_in;

   // datapath signals
   logic                     req_accept;
   logic                     rsp_free;
   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic [ACC_W-1:0]         mul_ext;
   logic [ACC_W-1:0]         acc_hi_sum;
   logic [POS_W-1:0]         cell_pos;
   logic [15:0]              cell_frac;
   logic [DIM_W-1:0]         ncols, nrows;
   logic                     in_x, in_y;
   logic [16:0]              ca, cb, wx, wy;
   logic [COL_W-1:0]         col_sel;
   logic [ROW_W-1:0]         row_sel;
   logic                     wr_en, rd_en;
   logic [ADDR_W-1:0]        wr_addr, rd_addr;
   logic [31:0]              rd_data;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != bgi_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // shared multiplier
   assign mul_in  = mul_a * mul_b;
   assign mul_ext = {{(ACC_W-MUL_PW){mul_ff[MUL_PW-1]}}, mul_ff};

   // accumulator plus upper partial product, shared by coordinate and blend
   assign acc_hi_sum = acc_ff + (mul_ext << 16);

   // cell position: floor of position minus one half, plus ghost count
   assign cell_pos  = {{2{acc_hi_sum[63]}}, acc_hi_sum[63:32]}
                    - {{(POS_W-1){1'b0}}, ~acc_hi_sum[31]}
                    + {{(POS_W-3){1'b0}}, ghost_ff};
   assign cell_frac = {~acc_hi_sum[31], acc_hi_sum[30:16]};

   // grid in use, limited by storage
   assign ncols = (DIM_W'(cols_ff) < DIM_W'(GRID_COLS)) ? DIM_W'(cols_ff) : DIM_W'(GRID_COLS);
   assign nrows = (DIM_W'(rows_ff) < DIM_W'(GRID_ROWS)) ? DIM_W'(rows_ff) : DIM_W'(GRID_ROWS);
   assign in_x  = !cell_x_ff[POS_W-1]
               && ($signed(cell_x_ff + POS_W'(1)) < $signed(POS_W'(ncols)));
   assign in_y  = !cell_y_ff[POS_W-1]
               && ($signed(cell_y_ff + POS_W'(1)) < $signed(POS_W'(nrows)));

   // corner weights
   assign ca = bgi_pkg::ONE_Q16 - {1'b0, a_ff};
   assign cb = bgi_pkg::ONE_Q16 - {1'b0, b_ff};
   assign wx = corner_ff[0] ? {1'b0, a_ff} : ca;
   assign wy = corner_ff[1] ? {1'b0, b_ff} : cb;

   // corner address
   assign col_sel = COL_W'(col_ff + COL_W'(corner_ff[0]));
   assign row_sel = ROW_W'(row_ff + ROW_W'(corner_ff[1]));
   assign rd_addr = ADDR_W'(ADDR_W'(row_sel) * ADDR_W'(GRID_COLS)) + ADDR_W'(col_sel);
   assign rd_en   = (state_ff == bgi_pkg::ST_WEIGHT);

   // cell writes go straight to the grid memory
   assign wr_en   = req_accept && (req_operation == bgi_pkg::OP_WRITE)
                 && (DIM_W'(req_write_col) < DIM_W'(GRID_COLS))
                 && (DIM_W'(req_write_row) < DIM_W'(GRID_ROWS));
   assign wr_addr = ADDR_W'(ADDR_W'(req_write_row) * ADDR_W'(GRID_COLS))
                  + ADDR_W'(req_write_col);

   bgi_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_cell_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         bgi_pkg::ST_X_LO: begin
            mul_a = $signed({dx_ff[32], dx_ff});
            mul_b = $signed({2'b00, inv_dx_ff[15:0]});
         end
         bgi_pkg::ST_X_HI: begin
            mul_a = $signed({dx_ff[32], dx_ff});
            mul_b = $signed({3'b000, inv_dx_ff[30:16]});
         end
         bgi_pkg::ST_Y_LO: begin
            mul_a = $signed({dy_ff[32], dy_ff});
            mul_b = $signed({2'b00, inv_dy_ff[15:0]});
         end
         bgi_pkg::ST_Y_HI: begin
            mul_a = $signed({dy_ff[32], dy_ff});
            mul_b = $signed({3'b000, inv_dy_ff[30:16]});
         end
         bgi_pkg::ST_WEIGHT: begin
            mul_a = $signed({{(MUL_AW-17){1'b0}}, wx});
            mul_b = $signed({1'b0, wy});
         end
         bgi_pkg::ST_PROD_LO: begin
            mul_a = $signed({{2{rd_data[31]}}, rd_data});
            mul_b = $signed({2'b00, mul_ff[15:0]});
         end
         bgi_pkg::ST_PROD_HI: begin
            mul_a = $signed({{2{rd_data[31]}}, rd_data});
            mul_b = $signed({1'b0, whi_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      corner_in    = corner_ff;
      fault_in     = fault_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      acc_in       = acc_ff;
      cell_x_in    = cell_x_ff;
      cell_y_in    = cell_y_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      whi_in       = whi_ff;
      rsp_value_in = rsp_value_ff;
      rsp_oog_in   = rsp_oog_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         bgi_pkg::ST_IDLE: begin
            if (req_accept && (req_operation == bgi_pkg::OP_INTERP)) begin
               dx_in    = {req_x_pos[31], req_x_pos} - {x_lower_ff[31], x_lower_ff};
               dy_in    = {req_y_pos[31], req_y_pos} - {y_lower_ff[31], y_lower_ff};
               state_in = bgi_pkg::ST_X_LO;
            end
         end
         bgi_pkg::ST_X_LO: begin
            state_in = bgi_pkg::ST_X_HI;
         end
         bgi_pkg::ST_X_HI: begin
            acc_in   = mul_ext;
            state_in = bgi_pkg::ST_Y_LO;
         end
         bgi_pkg::ST_Y_LO: begin
            cell_x_in = cell_pos;
            a_in      = cell_frac;
            state_in  = bgi_pkg::ST_Y_HI;
         end
         bgi_pkg::ST_Y_HI: begin
            acc_in   = mul_ext;
            state_in = bgi_pkg::ST_Y_END;
         end
         bgi_pkg::ST_Y_END: begin
            cell_y_in = cell_pos;
            b_in      = cell_frac;
            state_in  = bgi_pkg::ST_CHECK;
         end
         bgi_pkg::ST_CHECK: begin
            fault_in  = !(in_x && in_y);
            col_in    = cell_x_ff[COL_W-1:0];
            row_in    = cell_y_ff[ROW_W-1:0];
            corner_in = '0;
            state_in  = (in_x && in_y) ? bgi_pkg::ST_WEIGHT : bgi_pkg::ST_OUT;
         end
         // weight for this corner; fold in upper product of the previous one
         bgi_pkg::ST_WEIGHT: begin
            acc_in   = (corner_ff == 2'd0) ? bgi_pkg::ROUND_HALF : acc_hi_sum;
            state_in = bgi_pkg::ST_PROD_LO;
         end
         bgi_pkg::ST_PROD_LO: begin
            whi_in   = mul_ff[32:16];
            state_in = bgi_pkg::ST_PROD_HI;
         end
         bgi_pkg::ST_PROD_HI: begin
            acc_in = acc_ff + mul_ext;
            if (corner_ff == 2'd3) begin
               state_in = bgi_pkg::ST_SUM;
            end else begin
               corner_in = corner_ff + 2'd1;
               state_in  = bgi_pkg::ST_WEIGHT;
            end
         end
         bgi_pkg::ST_SUM: begin
            acc_in   = acc_hi_sum;
            state_in = bgi_pkg::ST_OUT;
         end
         // hand the result to the output register once it is free
         bgi_pkg::ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = fault_ff ? 32'h0000_0000 : acc_ff[63:32];
               rsp_oog_in   = fault_ff;
               state_in     = bgi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bgi_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bgi_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         corner_ff    <= '0;
         fault_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         corner_ff    <= corner_in;
         fault_ff     <= fault_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_lower_ff <= bgi_pkg::X_LOWER_RST;
         y_lower_ff <= bgi_pkg::Y_LOWER_RST;
         inv_dx_ff  <= bgi_pkg::INV_DX_RST;
         inv_dy_ff  <= bgi_pkg::INV_DY_RST;
         ghost_ff   <= bgi_pkg::GHOST_CELLS_RST;
         cols_ff    <= bgi_pkg::COLS_IN_USE_RST;
         rows_ff    <= bgi_pkg::ROWS_IN_USE_RST;
      end else if (csr_valid && csr_ready) begin
         case (bgi_pkg::bgi_csr_type'(csr_index))
            bgi_pkg::CSR_X_LOWER:     x_lower_ff <= csr_wdata;
            bgi_pkg::CSR_Y_LOWER:     y_lower_ff <= csr_wdata;
            bgi_pkg::CSR_INV_DX:      inv_dx_ff  <= csr_wdata[30:0];
            bgi_pkg::CSR_INV_DY:      inv_dy_ff  <= csr_wdata[30:0];
            bgi_pkg::CSR_GHOST_CELLS: ghost_ff   <= csr_wdata[2:0];
            bgi_pkg::CSR_COLS_IN_USE: cols_ff    <= csr_wdata[6:0];
            bgi_pkg::CSR_ROWS_IN_USE: rows_ff    <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      acc_ff       <= acc_in;
      mul_ff       <= mul_in;
      cell_x_ff    <= cell_x_in;
      cell_y_ff    <= cell_y_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      whi_ff       <= whi_in;
      rsp_value_ff <= rsp_value_in;
      rsp_oog_ff   <= rsp_oog_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_out_of_grid  = rsp_oog_ff;

endmodule

// ===== rtl/core/bgi_checker.sv =====
// bgi_checker: port-level checks on the bilinear grid interpolator
// depends on bgi_pkg; bound to bilinear_grid_interpolator_core below
module bgi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_operation,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_interp_value,
   input logic        rsp_out_of_grid
);

   // an interpolation keeps the request side closed on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_operation == bgi_pkg::OP_INTERP)) |=> req_stall)
      else $error("request side open right after an interpolate item");

   // a write item leaves the block ready for the next item
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_operation == bgi_pkg::OP_WRITE)) |=> !req_stall)
      else $error("write item closed the request side");

   // no result appears on the cycle after any accepted item
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared directly after an accepted item");

   // an out of grid result carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_grid) |-> (rsp_interp_value == 32'h0000_0000))
      else $error("out of grid result with non-zero value");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_interp_value)
                                    && $stable(rsp_out_of_grid)))
      else $error("stalled result changed");

endmodule

bind bilinear_grid_interpolator_core bgi_checker u_bgi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_operation    (req_operation),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_interp_value (rsp_interp_value),
   .rsp_out_of_grid  (rsp_out_of_grid)
);
